FILE: hw/rtl/hpq_pkg.sv
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared widths, operation and status codes and cell control types for the
// min-heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

   localparam int FUNC_W   = 2;
   localparam int KEY_W    = 32;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   localparam logic [FUNC_W-1:0] OP_INSERT   = 2'd0;
   localparam logic [FUNC_W-1:0] OP_EXTRACT  = 2'd1;
   localparam logic [FUNC_W-1:0] OP_DECREASE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

   // where a level cell takes its write data from
   typedef enum logic [1:0] {
      SRC_KEY,
      SRC_UP,
      SRC_DOWN
   } hpq_src_type;

   typedef struct packed {
      logic        rd_en;
      logic        wr_en;
      hpq_src_type wr_src;
      logic        lvalid;
      logic        rvalid;
   } hpq_cell_ctl_type;

   typedef struct packed {
      logic up_take;
      logic down_take;
      logic down_right;
   } hpq_cell_rsp_type;

endpackage

FILE: hw/rtl/hpq_req_if.sv
// ----------------------------------------------------------------------------
// hpq_req_if
// Request channel: operation, key and heap slot, with valid/ready.
// ----------------------------------------------------------------------------
interface hpq_req_if
   import hpq_pkg::*;
;
   logic                    valid;
   logic                    ready;
   logic [FUNC_W-1:0]       func;
   logic signed [KEY_W-1:0] key_value;
   logic [SLOT_W-1:0]       slot_index;

   modport source (output valid, output func, output key_value, output slot_index,
                   input ready);
   modport sink (input valid, input func, input key_value, input slot_index,
                 output ready);
endinterface

FILE: hw/rtl/hpq_rsp_if.sv
// ----------------------------------------------------------------------------
// hpq_rsp_if
// Response channel: extracted key, status and entry count, with valid/ready.
// ----------------------------------------------------------------------------
interface hpq_rsp_if
   import hpq_pkg::*;
;
   logic                    valid;
   logic                    ready;
   logic signed [KEY_W-1:0] min_value;
   logic [STATUS_W-1:0]     status;
   logic [COUNT_W-1:0]      entry_count;

   modport source (output valid, output min_value, output status, output entry_count,
                   input ready);
   modport sink (input valid, input min_value, input status, input entry_count,
                 output ready);
endinterface

FILE: hw/rtl/hpq_level_cell.sv
// ----------------------------------------------------------------------------
// hpq_level_cell
// One level of the heap tree: a key memory with two registered read ports,
// one write port fed from the moving key or a neighbouring level, and the
// compares for a sift step against that level's read data.
// ----------------------------------------------------------------------------
module hpq_level_cell
   import hpq_pkg::*;
#(
   parameter int LEVEL = 0,
   parameter int OFS_W = 1
) (
   input  logic                    clock,
   input  hpq_cell_ctl_type        ctl,
   input  logic [OFS_W-1:0]        rd_addr_a,
   input  logic [OFS_W-1:0]        rd_addr_b,
   input  logic [OFS_W-1:0]        wr_addr,
   input  logic signed [KEY_W-1:0] key,
   input  logic signed [KEY_W-1:0] up_data,
   input  logic signed [KEY_W-1:0] down_data,
   output logic signed [KEY_W-1:0] rd_a,
   output logic signed [KEY_W-1:0] best_value,
   output hpq_cell_rsp_type        rsp
);

   localparam int AW    = (LEVEL > 0) ? LEVEL : 1;
   localparam int DEPTH = 1 << AW;

   logic signed [KEY_W-1:0] key_mem [DEPTH];
   logic signed [KEY_W-1:0] rd_a_ff;
   logic signed [KEY_W-1:0] rd_b_ff;
   logic signed [KEY_W-1:0] wr_data;

   always_comb begin
      case (ctl.wr_src)
         SRC_UP:   wr_data = up_data;
         SRC_DOWN: wr_data = down_data;
         default:  wr_data = key;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         key_mem[wr_addr[AW-1:0]] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_a_ff <= key_mem[rd_addr_a[AW-1:0]];
         rd_b_ff <= key_mem[rd_addr_b[AW-1:0]];
      end
   end

   // as a child level: smaller child strictly below the key, left wins a tie
   always_comb begin
      best_value     = key;
      rsp.down_take  = 1'b0;
      rsp.down_right = 1'b0;
      if (ctl.lvalid && (rd_a_ff < key)) begin
         best_value    = rd_a_ff;
         rsp.down_take = 1'b1;
      end
      if (ctl.rvalid && (rd_b_ff < best_value)) begin
         best_value     = rd_b_ff;
         rsp.down_take  = 1'b1;
         rsp.down_right = 1'b1;
      end
      // as a parent level: parent strictly above the key moves down
      rsp.up_take = rd_a_ff > key;
   end

   assign rd_a = rd_a_ff;

endmodule

FILE: hw/rtl/min_heap_priority_queue_core.sv
// ----------------------------------------------------------------------------
// min_heap_priority_queue_core
// Binary min-heap priority queue: insert, extract-min and decrease-key.
// ----------------------------------------------------------------------------
// The heap is kept as a row of level cells, one per tree level, each with its
// own key memory; node n (slot n-1) lives in level floor(log2 n). Insert and
// decrease-key climb the key level by level, with the read of the next parent
// overlapping each write. Extract fetches the root and the last entry together,
// then sinks the last key level by level (registered read of the child level,
// then compare and write), and stops after that load when it empties the heap.
// A full insert, an empty extract, a bad slot or the unused code goes straight
// to the finishing state. One item is worked at a time; the result sits in an
// output register, so the next item is taken while it waits, and the finishing
// state stalls only while that register is still full. The key memories hold
// no reset value and need no clearing pass: only slots below the entry count
// are ever read.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_core
   import hpq_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input logic        clock,
   input logic        reset,
   hpq_req_if.sink    req_chan,
   hpq_rsp_if.source  rsp_chan
);

   localparam int LEVELS = $clog2(CAPACITY + 1);
   localparam int CNT_W  = LEVELS;
   localparam int LVL_W  = $clog2(LEVELS);
   localparam int OFS_W  = LEVELS - 1;
   localparam int CMP_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EX_LOAD,
      S_UP_READ,
      S_UP_CMP,
      S_DN_READ,
      S_DN_CMP,
      S_DONE
   } state_type;

   function automatic logic [LVL_W-1:0] msb_of(input logic [CNT_W-1:0] n);
      logic [LVL_W-1:0] r;
      r = '0;
      for (int i = 0; i < CNT_W; i++) begin
         if (n[i]) begin
            r = LVL_W'(i);
         end
      end
      return r;
   endfunction

   // position of a node inside its level's memory
   function automatic logic [OFS_W-1:0] ofs_of(input logic [CNT_W-1:0] n,
                                                input logic [LVL_W-1:0] l);
      logic [CNT_W-1:0] m;
      m    = n;
      m[l] = 1'b0;
      return m[OFS_W-1:0];
   endfunction

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        node_ff, node_in;
   logic [LVL_W-1:0]        lvl_ff, lvl_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic signed [KEY_W-1:0] res_min_ff, res_min_in;
   logic [STATUS_W-1:0]     res_status_ff, res_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [KEY_W-1:0] rsp_min_ff, rsp_min_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   hpq_cell_ctl_type        cell_ctl [LEVELS];
   hpq_cell_rsp_type        cell_rsp [LEVELS];
   logic [OFS_W-1:0]        addr_a [LEVELS];
   logic [OFS_W-1:0]        addr_b [LEVELS];
   logic [OFS_W-1:0]        waddr [LEVELS];
   logic signed [KEY_W-1:0] rd_a_arr [LEVELS];
   logic signed [KEY_W-1:0] best_arr [LEVELS];
   logic signed [KEY_W-1:0] up_link [LEVELS];
   logic signed [KEY_W-1:0] down_link [LEVELS];

   // access request for this cycle
   logic                    rd_en;
   logic                    root_rd;
   logic [LVL_W-1:0]        rd_lvl;
   logic [OFS_W-1:0]        rd_ofs_a;
   logic [OFS_W-1:0]        rd_ofs_b;
   logic                    wr_en;
   hpq_src_type             wr_src;
   logic                    kid_lvalid;
   logic                    kid_rvalid;

   logic [CMP_W-1:0]        slot_ext;
   logic [CMP_W-1:0]        cnt_ext;
   logic [CNT_W-1:0]        node_ins;
   logic [CNT_W-1:0]        node_dec;
   logic [LVL_W-1:0]        last_lvl;
   logic [LVL_W-1:0]        parent_lvl;
   logic [LVL_W-1:0]        gp_lvl;
   logic [LVL_W-1:0]        child_lvl;
   logic [CNT_W:0]          child_l;
   logic [CNT_W:0]          child_r;
   logic                    has_l;
   logic                    has_r;

   assign slot_ext   = CMP_W'(req_chan.slot_index);
   assign cnt_ext    = CMP_W'(count_ff);
   assign node_ins   = count_ff + CNT_W'(1);
   assign node_dec   = CNT_W'(slot_ext + CMP_W'(1));
   assign last_lvl   = msb_of(count_ff);
   assign parent_lvl = lvl_ff - LVL_W'(1);
   assign gp_lvl     = lvl_ff - LVL_W'(2);
   assign child_lvl  = lvl_ff + LVL_W'(1);
   assign child_l    = {node_ff, 1'b0};
   assign child_r    = {node_ff, 1'b1};
   assign has_l      = child_l <= {1'b0, count_ff};
   assign has_r      = child_r <= {1'b0, count_ff};

   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      node_in       = node_ff;
      lvl_in        = lvl_ff;
      key_in        = key_ff;
      res_min_in    = res_min_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_min_in    = rsp_min_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rd_en         = 1'b0;
      root_rd       = 1'b0;
      rd_lvl        = lvl_ff;
      rd_ofs_a      = '0;
      rd_ofs_b      = '0;
      wr_en         = 1'b0;
      wr_src        = SRC_KEY;
      kid_lvalid    = 1'b0;
      kid_rvalid    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               res_min_in    = '0;
               res_status_in = ST_OK;
               key_in        = req_chan.key_value;
               state_in      = S_DONE;
               case (req_chan.func)
                  OP_INSERT: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        node_in  = node_ins;
                        lvl_in   = msb_of(node_ins);
                        count_in = node_ins;
                        state_in = S_UP_READ;
                     end
                  end
                  OP_EXTRACT: begin
                     if (count_ff == '0) begin
                        res_min_in    = KEY_MAX;
                        res_status_in = ST_EMPTY;
                     end else begin
                        // fetch root and last entry together
                        rd_en    = 1'b1;
                        root_rd  = 1'b1;
                        rd_lvl   = last_lvl;
                        rd_ofs_a = ofs_of(count_ff, last_lvl);
                        lvl_in   = last_lvl;
                        count_in = count_ff - CNT_W'(1);
                        state_in = S_EX_LOAD;
                     end
                  end
                  OP_DECREASE: begin
                     if (slot_ext >= cnt_ext) begin
                        res_status_in = ST_BAD_INDEX;
                     end else begin
                        node_in  = node_dec;
                        lvl_in   = msb_of(node_dec);
                        state_in = S_UP_READ;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_EX_LOAD: begin
            res_min_in = rd_a_arr[0];
            key_in     = rd_a_arr[lvl_ff];
            if (count_ff == '0) begin
               state_in = S_DONE;
            end else begin
               node_in  = CNT_W'(1);
               lvl_in   = '0;
               state_in = S_DN_READ;
            end
         end

         S_UP_READ: begin
            if (lvl_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_lvl   = parent_lvl;
               rd_ofs_a = ofs_of(node_ff >> 1, parent_lvl);
               state_in = S_UP_CMP;
            end
         end

         S_UP_CMP: begin
            wr_en = 1'b1;
            if (cell_rsp[parent_lvl].up_take) begin
               // parent moves down; grandparent read overlaps the write
               wr_src  = SRC_UP;
               node_in = node_ff >> 1;
               lvl_in  = parent_lvl;
               if (parent_lvl != '0) begin
                  rd_en    = 1'b1;
                  rd_lvl   = gp_lvl;
                  rd_ofs_a = ofs_of(node_ff >> 2, gp_lvl);
               end else begin
                  state_in = S_UP_READ;
               end
            end else begin
               state_in = S_DONE;
            end
         end

         S_DN_READ: begin
            if (!has_l) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_lvl   = child_lvl;
               rd_ofs_a = ofs_of(child_l[CNT_W-1:0], child_lvl);
               rd_ofs_b = ofs_of(child_r[CNT_W-1:0], child_lvl);
               state_in = S_DN_CMP;
            end
         end

         S_DN_CMP: begin
            wr_en      = 1'b1;
            kid_lvalid = has_l;
            kid_rvalid = has_r;
            if (cell_rsp[child_lvl].down_take) begin
               wr_src   = SRC_DOWN;
               node_in  = cell_rsp[child_lvl].down_right ? child_r[CNT_W-1:0]
                                                         : child_l[CNT_W-1:0];
               lvl_in   = child_lvl;
               state_in = S_DN_READ;
            end else begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_min_in    = res_min_ff;
               rsp_status_in = res_status_ff;
               rsp_count_in  = COUNT_W'(count_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // fan the request out to the level cells; level 0 holds the root only
   always_comb begin
      for (int c = 0; c < LEVELS; c++) begin
         cell_ctl[c].rd_en  = (rd_en && (rd_lvl == LVL_W'(c))) || (root_rd && (c == 0));
         cell_ctl[c].wr_en  = wr_en && (lvl_ff == LVL_W'(c));
         cell_ctl[c].wr_src = wr_src;
         cell_ctl[c].lvalid = kid_lvalid;
         cell_ctl[c].rvalid = kid_rvalid;
         addr_a[c]          = (c == 0) ? '0 : rd_ofs_a;
         addr_b[c]          = (c == 0) ? '0 : rd_ofs_b;
         waddr[c]           = (c == 0) ? '0 : ofs_of(node_ff, lvl_ff);
      end
   end

   for (genvar g = 0; g < LEVELS; g++) begin : g_level
      if (g == 0) begin : g_top
         assign up_link[g] = '0;
      end else begin : g_mid
         assign up_link[g] = rd_a_arr[g-1];
      end
      if (g == LEVELS - 1) begin : g_leaf
         assign down_link[g] = '0;
      end else begin : g_inner
         assign down_link[g] = best_arr[g+1];
      end

      hpq_level_cell #(
         .LEVEL (g),
         .OFS_W (OFS_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[g]),
         .rd_addr_a  (addr_a[g]),
         .rd_addr_b  (addr_b[g]),
         .wr_addr    (waddr[g]),
         .key        (key_ff),
         .up_data    (up_link[g]),
         .down_data  (down_link[g]),
         .rd_a       (rd_a_arr[g]),
         .best_value (best_arr[g]),
         .rsp        (cell_rsp[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff       <= node_in;
      lvl_ff        <= lvl_in;
      key_ff        <= key_in;
      res_min_ff    <= res_min_in;
      res_status_ff <= res_status_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.min_value   = rsp_min_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_count_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.valid && req_chan.ready) |=> $stable(count_ff))
      else $error("entry count changed without an accepted item");

   a_up_cmp_not_root: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UP_CMP |-> lvl_ff != '0)
      else $error("sift-up compare issued at the root");

   a_done_loads_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready)
      |=> rsp_chan.valid && (rsp_chan.status == $past(res_status_ff)))
      else $error("finished result not presented");
`endif

endmodule

FILE: sim/hpq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_checker
// Watches the request and response channels of the heap queue, keeps its own
// mirror of the heap, predicts one result per accepted item and compares every
// accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module hpq_checker
   import hpq_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic clock,
   input  logic reset,
   hpq_req_if   req_mon,
   hpq_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count,
   output int   checked_count,
   output int   status_hits [4]
);

   typedef struct packed {
      logic signed [KEY_W-1:0] min_value;
      logic [STATUS_W-1:0]     status;
      logic [COUNT_W-1:0]      entry_count;
   } hpq_outcome_type;

   logic signed [KEY_W-1:0] heap_mirror [CAPACITY];
   int                      occupancy;
   hpq_outcome_type         predicted_outcomes [$];
   int                      fails;
   int                      checked;

   function automatic void swap_mirror(int a, int b);
      logic signed [KEY_W-1:0] tmp;
      tmp            = heap_mirror[a];
      heap_mirror[a] = heap_mirror[b];
      heap_mirror[b] = tmp;
   endfunction

   // climb while the parent is strictly larger
   function automatic void float_up(int pos);
      int parent;
      while (pos != 0) begin
         parent = (pos - 1) / 2;
         if (heap_mirror[parent] <= heap_mirror[pos])
            break;
         swap_mirror(pos, parent);
         pos = parent;
      end
   endfunction

   // sink toward the smaller child; left wins a tie between children
   function automatic void settle_down(int pos);
      int lt;
      int rt;
      int best;
      bit done;
      done = 1'b0;
      while (!done) begin
         lt   = 2 * pos + 1;
         rt   = 2 * pos + 2;
         best = pos;
         if (lt < occupancy && heap_mirror[lt] < heap_mirror[best])
            best = lt;
         if (rt < occupancy && heap_mirror[rt] < heap_mirror[best])
            best = rt;
         if (best == pos) begin
            done = 1'b1;
         end else begin
            swap_mirror(pos, best);
            pos = best;
         end
      end
   endfunction

   function automatic hpq_outcome_type apply_heap_op(logic [FUNC_W-1:0] func,
                                                     logic signed [KEY_W-1:0] key,
                                                     logic [SLOT_W-1:0] slot);
      hpq_outcome_type res;
      res.min_value = '0;
      res.status    = ST_OK;
      case (func)
         OP_INSERT: begin
            if (occupancy >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               heap_mirror[occupancy] = key;
               occupancy++;
               float_up(occupancy - 1);
            end
         end
         OP_EXTRACT: begin
            if (occupancy == 0) begin
               res.min_value = KEY_MAX;
               res.status    = ST_EMPTY;
            end else begin
               res.min_value  = heap_mirror[0];
               occupancy--;
               heap_mirror[0] = heap_mirror[occupancy];
               settle_down(0);
            end
         end
         OP_DECREASE: begin
            if (int'(slot) >= occupancy) begin
               res.status = ST_BAD_INDEX;
            end else begin
               // no check that the key really goes down
               heap_mirror[slot] = key;
               float_up(int'(slot));
            end
         end
         default: ;
      endcase
      res.entry_count = COUNT_W'(occupancy);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      hpq_outcome_type want;
      bit              bad;
      if (reset) begin
         occupancy = 0;
         predicted_outcomes.delete();
         fails   = 0;
         checked = 0;
         for (int s = 0; s < 4; s++)
            status_hits[s] <= 0;
      end else begin
         // result first: it can never belong to an item taken at this edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_outcomes.size() == 0) begin
               $display("%0t: result with nothing expected: min_value %0d status %0d count %0d",
                        $time, rsp_mon.min_value, rsp_mon.status, rsp_mon.entry_count);
               fails++;
            end else begin
               want = predicted_outcomes.pop_front();
               bad  = 1'b0;
               if (rsp_mon.min_value !== want.min_value) begin
                  $display("%0t: min_value mismatch: expected %0d, actual %0d",
                           $time, want.min_value, rsp_mon.min_value);
                  bad = 1'b1;
               end
               if (rsp_mon.status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_mon.status);
                  bad = 1'b1;
               end
               if (rsp_mon.entry_count !== want.entry_count) begin
                  $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                           $time, want.entry_count, rsp_mon.entry_count);
                  bad = 1'b1;
               end
               if (bad)
                  fails++;
               checked++;
               status_hits[want.status] <= status_hits[want.status] + 1;
            end
         end
         if (req_mon.valid && req_mon.ready)
            predicted_outcomes.push_back(apply_heap_op(req_mon.func, req_mon.key_value,
                                                       req_mon.slot_index));
      end
      fail_count    <= fails;
      checked_count <= checked;
      pending_count <= predicted_outcomes.size();
   end

endmodule

FILE: sim/tb_min_heap_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_heap_priority_queue_core
// Drives the heap queue with a directed opening and then random phases that
// fill, drain and churn the heap, with random gaps on both channels. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_min_heap_priority_queue_core;
   import hpq_pkg::*;

   localparam int CAPACITY  = 64;
   localparam int RUN_LIMIT = 200000;
   localparam int SEG_ITEMS = 64;
   localparam int SEGMENTS  = 7;

   localparam logic [FUNC_W-1:0]       OP_UNUSED = 2'd3;
   localparam logic signed [KEY_W-1:0] KEY_MIN   = 32'sh8000_0000;

   typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_NOISE} mix_mode_type;

   logic clock;
   logic reset;
   logic rx_ready    = 1'b0;
   int   stall_left  = 0;
   bit   rx_quiet    = 1'b0;
   bit   tx_quiet    = 1'b0;
   int   cycle_count = 0;
   int   fill_level  = 0;
   int   sent_by_op [4];

   int fail_count;
   int pending_count;
   int checked_count;
   int status_hits [4];

   hpq_req_if req_chan ();
   hpq_rsp_if rsp_chan ();

   assign rsp_chan.ready = rx_ready;

   min_heap_priority_queue_core #(.CAPACITY(CAPACITY)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   hpq_checker #(.CAPACITY(CAPACITY)) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .status_hits   (status_hits)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // mostly short, now and then long
   function automatic int pick_gap(int long_hi);
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      else if (r < 93)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, long_hi);
   endfunction

   // response side back-pressure, with quiet stretches
   always @(posedge clock) begin : rx_pace
      int len;
      if (reset) begin
         rx_ready   <= 1'b0;
         stall_left <= 0;
      end else begin
         if (cycle_count % 256 == 0)
            rx_quiet <= ($urandom_range(0, 3) == 0);
         if (stall_left > 0) begin
            rx_ready   <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (!rx_quiet && $urandom_range(0, 99) < 15) begin
            len        = pick_gap(40);
            rx_ready   <= (len == 0);
            stall_left <= (len > 0) ? len - 1 : 0;
         end else begin
            rx_ready <= 1'b1;
         end
      end
   end

   // valid is only lowered ahead of a gap, so it never toggles within one step
   task automatic send_item(input logic [FUNC_W-1:0] func,
                            input logic signed [KEY_W-1:0] key,
                            input logic [SLOT_W-1:0] slot);
      int gap;
      gap = tx_quiet ? 0 : pick_gap(30);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.func       <= func;
      req_chan.key_value  <= key;
      req_chan.slot_index <= slot;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_by_op[func]++;
      if (func == OP_INSERT && fill_level < CAPACITY)
         fill_level++;
      else if (func == OP_EXTRACT && fill_level > 0)
         fill_level--;
   endtask

   task automatic wait_all_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      mix_mode_type            mode;
      logic [FUNC_W-1:0]       op;
      logic signed [KEY_W-1:0] key;
      logic [SLOT_W-1:0]       slot;
      int                      r;

      for (int k = 0; k < 4; k++)
         sent_by_op[k] = 0;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.func       <= OP_INSERT;
      req_chan.key_value  <= '0;
      req_chan.slot_index <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty heap: extract, decrease, unused selector
      send_item(OP_EXTRACT, 32'sd0, 6'd0);
      send_item(OP_DECREASE, 32'sd3, 6'd0);
      send_item(OP_UNUSED, '1, 6'd63);
      // extremes and a repeated key
      send_item(OP_INSERT, 32'sd5, 6'd0);
      send_item(OP_INSERT, KEY_MAX, 6'd63);
      send_item(OP_INSERT, KEY_MIN, 6'd0);
      send_item(OP_INSERT, 32'sd0, 6'd0);
      send_item(OP_INSERT, 32'sd5, 6'd0);
      send_item(OP_INSERT, -32'sd1, 6'd0);
      // slot equal to the count and far beyond it
      send_item(OP_DECREASE, 32'sd1, 6'd6);
      send_item(OP_DECREASE, 32'sd1, 6'd63);
      // new key equal to the root, then a larger key, then a real decrease
      send_item(OP_DECREASE, KEY_MIN, 6'd5);
      send_item(OP_DECREASE, KEY_MAX, 6'd1);
      send_item(OP_DECREASE, -32'sd7, 6'd3);
      send_item(OP_UNUSED, KEY_MIN, 6'd2);
      repeat (7) send_item(OP_EXTRACT, '1, 6'd63);
      send_item(OP_INSERT, KEY_MAX, 6'd0);
      send_item(OP_EXTRACT, 32'sd0, 6'd0);
      send_item(OP_EXTRACT, 32'sd0, 6'd0);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg % 2 == 0)
            wait_all_results();
         case (seg)
            0, 1:    mode = MODE_FILL;
            3, 4:    mode = MODE_DRAIN;
            6:       mode = MODE_NOISE;
            default: mode = MODE_MIXED;
         endcase
         tx_quiet = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < SEG_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            case (mode)
               MODE_FILL:  op = (r < 80) ? OP_INSERT : (r < 88) ? OP_DECREASE :
                                (r < 96) ? OP_EXTRACT : OP_UNUSED;
               MODE_DRAIN: op = (r < 75) ? OP_EXTRACT : (r < 85) ? OP_INSERT :
                                (r < 97) ? OP_DECREASE : OP_UNUSED;
               MODE_MIXED: op = (r < 40) ? OP_INSERT : (r < 75) ? OP_EXTRACT :
                                (r < 97) ? OP_DECREASE : OP_UNUSED;
               default:    op = FUNC_W'($urandom_range(0, 3));
            endcase
            // narrow range now and then so that equal keys meet
            r = $urandom_range(0, 9);
            if (r == 0) begin
               case ($urandom_range(0, 3))
                  0:       key = KEY_MIN;
                  1:       key = KEY_MAX;
                  2:       key = '0;
                  default: key = '1;
               endcase
            end else if (r < 4) begin
               key = int'($urandom_range(0, 15)) - 8;
            end else begin
               key = $urandom;
            end
            if (fill_level > 0 && $urandom_range(0, 4) != 0)
               slot = SLOT_W'($urandom_range(0, fill_level - 1));
            else
               slot = SLOT_W'($urandom_range(0, 63));
            send_item(op, key, slot);
         end
      end

      wait_all_results();
      repeat (20) @(posedge clock);
      $display("Run covered %0d items: %0d insert, %0d extract, %0d decrease, %0d unused",
               sent_by_op[OP_INSERT] + sent_by_op[OP_EXTRACT] + sent_by_op[OP_DECREASE]
               + sent_by_op[OP_UNUSED], sent_by_op[OP_INSERT], sent_by_op[OP_EXTRACT],
               sent_by_op[OP_DECREASE], sent_by_op[OP_UNUSED]);
      $display("%0d results checked: %0d ok, %0d dropped when full, %0d empty, %0d bad slot",
               checked_count, status_hits[ST_OK], status_hits[ST_FULL],
               status_hits[ST_EMPTY], status_hits[ST_BAD_INDEX]);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
